>>> rtl/core/rv32_pkg.sv
package rv32_pkg;

  localparam int XLEN = 32;
  localparam int REG_COUNT_DEFAULT = 32;
  localparam int REG_IDX_W = 5;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;
  localparam logic [31:0] ECALL_READ  = 32'd1;
  localparam logic [31:0] ECALL_WRITE = 32'd2;
  localparam logic [31:0] ECALL_EXIT  = 32'd3;
  localparam logic [31:0] ECALL_EXIT2 = 32'd93;
  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  localparam logic [2:0] ACC_NONE    = 3'd0;
  localparam logic [2:0] ACC_LOAD    = 3'd1;
  localparam logic [2:0] ACC_STORE   = 3'd2;
  localparam logic [2:0] ACC_CONRD   = 3'd3;
  localparam logic [2:0] ACC_CONWR   = 3'd4;

  localparam logic [2:0] PEND_CONSOLE = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RS1,
    ST_RS2,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_signed;
  } div_ctrl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
  } div_stat_t;

endpackage

>>> rtl/core/rv32_ram.sv
module rv32_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/rv32_div.sv
module rv32_div
  import rv32_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_ctrl_t   ctrl,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output div_stat_t   stat,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] quo, dvs, rem;
  logic [5:0]  count;
  logic        neg_q, neg_r, busy, done;
  logic [32:0] trial;
  logic [31:0] ua, ub;

  assign ua = (ctrl.is_signed && dividend[31]) ? 32'(0 - dividend) : dividend;
  assign ub = (ctrl.is_signed && divisor[31]) ? 32'(0 - divisor) : divisor;
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= !ctrl.start && busy && (count == 6'd1);
      if (ctrl.start) begin
        busy <= 1'b1;
        count <= 6'd32;
        quo <= ua;
        rem <= '0;
        dvs <= ub;
        neg_q <= ctrl.is_signed && (dividend[31] ^ divisor[31]);
        neg_r <= ctrl.is_signed && dividend[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quotient = neg_q ? 32'(0 - quo) : quo;
  assign remainder = neg_r ? 32'(0 - rem) : rem;
endmodule

>>> rtl/core/rv32im_instruction_step.sv
// Steps from input word to result word: read rs1, read rs2, execute, output; divide
// and remainder add a divider phase, while data returns and skipped words go from the
// first read straight to output. s_axis_tready stays low until the result word is taken,
// so no new word is accepted before that. Register reads use one registered RAM port.
// Reset (rst, synchronous) loads the PC with zero, the reset start_address, and clears the
// pending load and halt state; registers read as zero until written, via a valid bit each.
module rv32im_instruction_step
  import rv32_pkg::*;
#(
  parameter int REGISTER_COUNT = REG_COUNT_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // instr_word, return_data
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata   // next_pc, access_kind, access_size, access_addr,
                                      // store_data, reg_write_valid, reg_write_index,
                                      // reg_write_value, halted, illegal_opcode
);
  state_t state, state_next;

  logic [31:0] pc, iw, rdata_in;
  logic        mode, awaiting, halt;
  logic [4:0]  pend_dest;
  logic [2:0]  pend_kind;
  logic [31:0] opa, opb, ram_q;
  logic [REGISTER_COUNT-1:0] rvalid;

  logic        ram_we;
  logic [4:0]  ram_raddr;
  logic [31:0] ram_wdata;
  logic [4:0]  ram_waddr;

  logic [31:0] o_pc, o_addr, o_sd, o_wv;
  logic [2:0]  o_kind;
  logic [1:0]  o_size;
  logic        o_wvld, o_halt, o_ill;
  logic [4:0]  o_wi;

  div_ctrl_t dctl;
  div_stat_t dst;
  logic [31:0] dq, dr;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd, rs1, rs2;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, alu_b, sum, shl, shr, sra_r;
  logic [4:0]  shamt;
  logic        lt_s, lt_u, eq, is_div, a7_ok;
  logic [31:0] prod;

  logic [31:0] e_pc, e_addr, e_sd, e_wv;
  logic [2:0]  e_kind;
  logic [1:0]  e_size;
  logic        e_wr, e_ill, e_halt, e_await;
  logic [4:0]  e_pdest;
  logic [2:0]  e_pkind;

  logic [31:0] ret_val;
  logic        ret_wr, exec_done;

  assign opc = iw[6:0];
  assign f3  = iw[14:12];
  assign f7  = iw[31:25];
  assign rd  = iw[11:7];
  assign rs1 = iw[19:15];
  assign rs2 = iw[24:20];
  assign imm_i = {{20{iw[31]}}, iw[31:20]};
  assign imm_s = {{20{iw[31]}}, iw[31:25], iw[11:7]};
  assign imm_b = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
  assign imm_j = {{11{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};

  assign alu_b = (opc == OP_REG || opc == OP_BRANCH) ? opb : imm_i;
  assign shamt = alu_b[4:0];
  assign shl = opa << shamt;
  assign shr = opa >> shamt;
  assign sra_r = $signed(opa) >>> shamt;
  assign lt_s = $signed(opa) < $signed(alu_b);
  assign lt_u = opa < alu_b;
  assign eq = opa == alu_b;
  assign sum = opa + ((opc == OP_STORE) ? imm_s : imm_i);
  assign is_div = opc == OP_REG && f7 == 7'h01 && f3[2];
  assign a7_ok = 1'b1;

  function automatic logic rf_ok(input logic [4:0] i);
    rf_ok = (i != 5'd0) && (32'(i) < REGISTER_COUNT);
  endfunction

  assign ret_wr = state == ST_RS1 && !halt && mode && awaiting && rf_ok(pend_dest);
  assign exec_done = (state == ST_EXEC && !is_div) || (state == ST_DIV && dst.done);

  always_comb begin
    case (pend_kind)
      3'd0: ret_val = {{24{rdata_in[7]}}, rdata_in[7:0]};
      3'd1: ret_val = {{16{rdata_in[15]}}, rdata_in[15:0]};
      3'd4: ret_val = {24'd0, rdata_in[7:0]};
      3'd5: ret_val = {16'd0, rdata_in[15:0]};
      default: ret_val = rdata_in;
    endcase
  end

  rv32_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_q)
  );

  rv32_div u_div (
    .clk(clk), .rst(rst), .ctrl(dctl), .dividend(opa), .divisor(opb),
    .stat(dst), .quotient(dq), .remainder(dr)
  );

  function automatic logic [31:0] rf_val(input logic [4:0] i, input logic [31:0] q,
                                         input logic [REGISTER_COUNT-1:0] v);
    logic ok;
    ok = rf_ok(i);
    if (ok && v[i[$clog2(REGISTER_COUNT)-1:0]]) rf_val = q;
    else rf_val = '0;
  endfunction

  // execute
  always_comb begin
    e_pc = pc + 32'd4;
    e_kind = ACC_NONE; e_size = '0; e_addr = '0; e_sd = '0;
    e_wr = 1'b0; e_wv = '0; e_ill = 1'b0; e_halt = 1'b0;
    e_await = 1'b0; e_pdest = pend_dest; e_pkind = pend_kind;
    prod = opa * opb;
    case (opc)
      OP_REG: begin
        if (f7 == 7'h00) begin
          e_wr = 1'b1;
          case (f3)
            3'd0: e_wv = opa + opb;
            3'd1: e_wv = shl;
            3'd2: e_wv = {31'd0, lt_s};
            3'd3: e_wv = {31'd0, lt_u};
            3'd4: e_wv = opa ^ opb;
            3'd5: e_wv = shr;
            3'd6: e_wv = opa | opb;
            default: e_wv = opa & opb;
          endcase
        end else if (f7 == 7'h20) begin
          if (f3 == 3'd0) begin e_wr = 1'b1; e_wv = opa - opb; end
          else if (f3 == 3'd5) begin e_wr = 1'b1; e_wv = sra_r; end
        end else if (f7 == 7'h01) begin
          case (f3)
            3'd0: begin e_wr = 1'b1; e_wv = prod[31:0]; end
            3'd4, 3'd5: begin
              e_wr = 1'b1;
              e_wv = (opb == 0) ? 32'hFFFFFFFF : dq;
            end
            3'd6, 3'd7: begin
              e_wr = 1'b1;
              e_wv = (opb == 0) ? opa : dr;
            end
            default: ;
          endcase
        end
      end
      OP_IMM: begin
        case (f3)
          3'd0: begin e_wr = 1'b1; e_wv = sum; end
          3'd1: if (f7 == 7'h00) begin e_wr = 1'b1; e_wv = shl; end
          3'd2: begin e_wr = 1'b1; e_wv = {31'd0, lt_s}; end
          3'd3: begin e_wr = 1'b1; e_wv = {31'd0, lt_u}; end
          3'd4: begin e_wr = 1'b1; e_wv = opa ^ imm_i; end
          3'd5: begin
            if (f7 == 7'h00) begin e_wr = 1'b1; e_wv = shr; end
            else if (f7 == 7'h20) begin e_wr = 1'b1; e_wv = sra_r; end
          end
          3'd6: begin e_wr = 1'b1; e_wv = opa | imm_i; end
          default: begin e_wr = 1'b1; e_wv = opa & imm_i; end
        endcase
      end
      OP_LOAD: begin
        if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) begin
          e_kind = ACC_LOAD; e_size = f3[1:0]; e_addr = sum;
          e_pdest = rd; e_pkind = f3; e_await = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 <= 3'd2) begin
          e_kind = ACC_STORE; e_size = f3[1:0]; e_addr = sum; e_sd = opb;
        end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: if (eq) e_pc = pc + imm_b;
          3'd1: if (!eq) e_pc = pc + imm_b;
          3'd4: if (lt_s) e_pc = pc + imm_b;
          3'd5: if (!lt_s) e_pc = pc + imm_b;
          3'd6: if (lt_u) e_pc = pc + imm_b;
          3'd7: if (!lt_u) e_pc = pc + imm_b;
          default: ;
        endcase
      end
      OP_JAL: begin
        e_pc = pc + imm_j; e_wr = 1'b1; e_wv = pc + 32'd4;
      end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          e_pc = {sum[31:1], 1'b0}; e_wr = 1'b1; e_wv = pc + 32'd4;
        end
      end
      OP_LUI: begin e_wr = 1'b1; e_wv = iw & UPPER_MASK; end
      OP_AUIPC: begin e_wr = 1'b1; e_wv = pc + (iw & UPPER_MASK); end
      OP_SYSTEM: begin
        if (opa == ECALL_READ) begin
          e_kind = ACC_CONRD; e_pdest = REG_A0; e_pkind = PEND_CONSOLE; e_await = 1'b1;
        end else if (opa == ECALL_WRITE) begin
          e_kind = ACC_CONWR; e_sd = opb;
        end else if ((opa == ECALL_EXIT || opa == ECALL_EXIT2) && a7_ok) begin
          e_halt = 1'b1;
        end
      end
      default: begin e_ill = 1'b1; e_halt = 1'b1; e_pc = pc; end
    endcase
    if (!rf_ok(rd)) e_wr = 1'b0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_RS1;
      ST_RS1: begin
        if (halt || mode || awaiting) state_next = ST_OUT;
        else state_next = ST_RS2;
      end
      ST_RS2: state_next = ST_EXEC;
      ST_EXEC: state_next = is_div ? ST_DIV : ST_OUT;
      ST_DIV: if (dst.done) state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = state == ST_IDLE;
    m_axis_tvalid = state == ST_OUT;
    dctl.start = state == ST_EXEC && is_div;
    dctl.is_signed = !f3[0];
    ram_raddr = rs1;
    if (state == ST_RS1) ram_raddr = (opc == OP_SYSTEM) ? REG_A0 : rs2;
    if (state == ST_IDLE) ram_raddr = (s_axis_tdata[6:0] == OP_SYSTEM) ? REG_A7
                                      : s_axis_tdata[19:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      awaiting <= 1'b0;
      halt <= 1'b0;
      pend_dest <= '0;
      pend_kind <= '0;
      rvalid <= '0;
      ram_we <= 1'b0;
    end else begin
      state <= state_next;
      ram_we <= ret_wr || (exec_done && e_wr);
      ram_waddr <= ret_wr ? pend_dest : rd;
      ram_wdata <= ret_wr ? ret_val : e_wv;
      if (cfg_we) begin
        pc <= cfg_wdata;
      end
      if (state == ST_IDLE && s_axis_tvalid) begin
        iw <= s_axis_tdata[31:0];
        rdata_in <= s_axis_tdata[63:32];
        mode <= s_axis_tuser;
      end
      if (state == ST_RS1) begin
        opa <= rf_val(opc == OP_SYSTEM ? REG_A7 : rs1, ram_q, rvalid);
        o_pc <= pc; o_kind <= ACC_NONE; o_size <= '0; o_addr <= '0; o_sd <= '0;
        o_wvld <= ret_wr; o_wi <= ret_wr ? pend_dest : 5'd0;
        o_wv <= ret_wr ? ret_val : 32'd0; o_halt <= halt; o_ill <= 1'b0;
        if (!halt && mode && awaiting) begin
          awaiting <= 1'b0;
        end
      end
      if (state == ST_RS2) begin
        opb <= rf_val(opc == OP_SYSTEM ? REG_A0 : rs2, ram_q, rvalid);
      end
      if (exec_done) begin
        pc <= e_pc; o_pc <= e_pc;
        o_kind <= e_kind; o_size <= e_size; o_addr <= e_addr; o_sd <= e_sd;
        o_wvld <= e_wr; o_wi <= e_wr ? rd : 5'd0; o_wv <= e_wr ? e_wv : 32'd0;
        o_ill <= e_ill; o_halt <= e_halt;
        halt <= e_halt;
        awaiting <= e_await; pend_dest <= e_pdest; pend_kind <= e_pkind;
      end
      if (ram_we && rf_ok(ram_waddr)) begin
        rvalid[ram_waddr[$clog2(REGISTER_COUNT)-1:0]] <= 1'b1;
      end
    end
  end

  assign m_axis_tdata = {3'd0, o_ill, o_halt, o_wv, o_wi, o_wvld, o_sd, o_addr,
                         o_size, o_kind, o_pc};

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) !(s_axis_tready && m_axis_tvalid))
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst) $past(halt) && !$past(rst) |-> halt)
    else $error("halt flag dropped");
  assert property (@(posedge clk) disable iff (rst) dctl.start |=> dst.busy)
    else $error("divider did not start");
`endif
endmodule

>>> test/rv32im_instruction_step_test.sv
`timescale 1ns / 100ps

module rv32im_instruction_step_test;
  import rv32_pkg::*;

  typedef struct packed {
    logic        illegal;
    logic        halted;
    logic [31:0] wr_value;
    logic [4:0]  wr_index;
    logic        wr_valid;
    logic [31:0] store_data;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [2:0]  kind;
    logic [31:0] next_pc;
  } step_result_t;

  class step_tracker;
    logic [31:0] regs [32];
    logic [31:0] pc;
    logic [4:0] pend_dest;
    logic [2:0] pend_kind;
    bit waiting;
    bit halt;
    step_result_t cur;
    step_result_t expected_results[$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      pend_dest = '0;
      pend_kind = '0;
      waiting = 0;
      halt = 0;
      errors = 0;
    endfunction

    function void load_start(logic [31:0] v);
      pc = v;
    endfunction

    function void put(logic [4:0] idx, logic [31:0] v);
      if (idx == 5'd0) return;
      regs[idx] = v;
      cur.wr_valid = 1'b1;
      cur.wr_index = idx;
      cur.wr_value = v;
    endfunction

    function logic [31:0] divide(logic [31:0] a, logic [31:0] b, logic [2:0] f3);
      logic signed [31:0] sa, sb;
      sa = a;
      sb = b;
      case (f3)
        3'd4: begin
          if (b == 0) return 32'hFFFFFFFF;
          if (a == 32'h80000000 && b == 32'hFFFFFFFF) return a;
          return sa / sb;
        end
        3'd5: return (b == 0) ? 32'hFFFFFFFF : a / b;
        3'd6: begin
          if (b == 0) return a;
          if (a == 32'h80000000 && b == 32'hFFFFFFFF) return '0;
          return sa % sb;
        end
        default: return (b == 0) ? a : a % b;
      endcase
    endfunction

    function void run_instr(logic [31:0] w);
      logic [31:0] a, b, nxt, imm_i, imm, a7;
      logic [4:0] rd, sh;
      logic [2:0] f3;
      logic [6:0] f7;
      bit take;
      rd = w[11:7];
      f3 = w[14:12];
      f7 = w[31:25];
      a = regs[w[19:15]];
      b = regs[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      sh = w[24:20];
      nxt = pc + 4;
      case (w[6:0])
        OP_REG: begin
          if (f7 == 7'h00) begin
            case (f3)
              3'd0: put(rd, a + b);
              3'd1: put(rd, a << b[4:0]);
              3'd2: put(rd, {31'd0, $signed(a) < $signed(b)});
              3'd3: put(rd, {31'd0, a < b});
              3'd4: put(rd, a ^ b);
              3'd5: put(rd, a >> b[4:0]);
              3'd6: put(rd, a | b);
              default: put(rd, a & b);
            endcase
          end else if (f7 == 7'h20) begin
            if (f3 == 3'd0) put(rd, a - b);
            else if (f3 == 3'd5) put(rd, $signed(a) >>> b[4:0]);
          end else if (f7 == 7'h01) begin
            if (f3 == 3'd0) put(rd, a * b);
            else if (f3 >= 3'd4) put(rd, divide(a, b, f3));
          end
        end
        OP_IMM: begin
          case (f3)
            3'd0: put(rd, a + imm_i);
            3'd1: if (f7 == 7'h00) put(rd, a << sh);
            3'd2: put(rd, {31'd0, $signed(a) < $signed(imm_i)});
            3'd3: put(rd, {31'd0, a < imm_i});
            3'd4: put(rd, a ^ imm_i);
            3'd5: begin
              if (f7 == 7'h00) put(rd, a >> sh);
              else if (f7 == 7'h20) put(rd, $signed(a) >>> sh);
            end
            3'd6: put(rd, a | imm_i);
            default: put(rd, a & imm_i);
          endcase
        end
        OP_LOAD: begin
          if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) begin
            cur.kind = ACC_LOAD;
            cur.size = f3[1:0];
            cur.addr = a + imm_i;
            pend_dest = rd;
            pend_kind = f3;
            waiting = 1;
          end
        end
        OP_STORE: begin
          if (f3 <= 3'd2) begin
            imm = {{20{w[31]}}, w[31:25], w[11:7]};
            cur.kind = ACC_STORE;
            cur.size = f3[1:0];
            cur.addr = a + imm;
            cur.store_data = b;
          end
        end
        OP_BRANCH: begin
          imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: take = 0;
          endcase
          if (take) nxt = pc + imm;
        end
        OP_JAL: begin
          imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
          nxt = pc + imm;
          put(rd, pc + 4);
        end
        OP_JALR: begin
          if (f3 == 3'd0) begin
            nxt = (a + imm_i) & ~32'd1;
            put(rd, pc + 4);
          end
        end
        OP_LUI: put(rd, w & UPPER_MASK);
        OP_AUIPC: put(rd, pc + (w & UPPER_MASK));
        OP_SYSTEM: begin
          a7 = regs[REG_A7];
          if (a7 == ECALL_READ) begin
            cur.kind = ACC_CONRD;
            pend_dest = REG_A0;
            pend_kind = PEND_CONSOLE;
            waiting = 1;
          end else if (a7 == ECALL_WRITE) begin
            cur.kind = ACC_CONWR;
            cur.store_data = regs[REG_A0];
          end else if (a7 == ECALL_EXIT || a7 == ECALL_EXIT2) begin
            halt = 1;
          end
        end
        default: begin
          cur.illegal = 1'b1;
          halt = 1;
          nxt = pc;
        end
      endcase
      pc = nxt;
    endfunction

    function void note_word(bit mode, logic [31:0] w, logic [31:0] d);
      logic [31:0] v;
      cur = '0;
      if (!halt) begin
        if (mode) begin
          if (waiting) begin
            case (pend_kind)
              3'd0: v = {{24{d[7]}}, d[7:0]};
              3'd1: v = {{16{d[15]}}, d[15:0]};
              3'd4: v = {24'd0, d[7:0]};
              3'd5: v = {16'd0, d[15:0]};
              default: v = d;
            endcase
            put(pend_dest, v);
            waiting = 0;
          end
        end else if (!waiting) begin
          run_instr(w);
        end
      end
      cur.next_pc = pc;
      cur.halted = halt;
      expected_results.push_back(cur);
    endfunction

    function void check_word(logic [143:0] data);
      step_result_t got, exp;
      got = data[140:0];
      if (expected_results.size() == 0) begin
        $error("result word with none expected: %h", data);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.next_pc !== exp.next_pc) begin
        $error("next_pc exp %h got %h", exp.next_pc, got.next_pc); errors++;
      end
      if (got.kind !== exp.kind) begin
        $error("access_kind exp %0d got %0d", exp.kind, got.kind); errors++;
      end
      if (got.size !== exp.size) begin
        $error("access_size exp %0d got %0d", exp.size, got.size); errors++;
      end
      if (got.addr !== exp.addr) begin
        $error("access_addr exp %h got %h", exp.addr, got.addr); errors++;
      end
      if (got.store_data !== exp.store_data) begin
        $error("store_data exp %h got %h", exp.store_data, got.store_data); errors++;
      end
      if (got.wr_valid !== exp.wr_valid) begin
        $error("reg_write_valid exp %0d got %0d", exp.wr_valid, got.wr_valid); errors++;
      end
      if (got.wr_index !== exp.wr_index) begin
        $error("reg_write_index exp %0d got %0d", exp.wr_index, got.wr_index); errors++;
      end
      if (got.wr_value !== exp.wr_value) begin
        $error("reg_write_value exp %h got %h", exp.wr_value, got.wr_value); errors++;
      end
      if (got.halted !== exp.halted) begin
        $error("halted exp %0d got %0d", exp.halted, got.halted); errors++;
      end
      if (got.illegal !== exp.illegal) begin
        $error("illegal_opcode exp %0d got %0d", exp.illegal, got.illegal); errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 3000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [143:0] m_axis_tdata;

  step_tracker sb = new();
  bit steady;
  int sink_hold;
  int idle_cycles;

  rv32im_instruction_step u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) sink_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] r_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] i_word(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] s_word(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] j_word(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_instr();
    logic [31:0] w;
    logic [6:0] f7;
    int r;
    w = $urandom;
    r = $urandom_range(0, 99);
    f7 = ($urandom_range(0, 9) == 0) ? 7'($urandom) : (($urandom_range(0, 1)) ? 7'h20 : 7'h00);
    if (r < 15) return {f7, w[24:7], OP_REG};
    if (r < 30) return {7'h01, w[24:7], OP_REG};
    if (r < 45) return {(w[14:12] inside {3'd1, 3'd5}) ? f7 : w[31:25], w[24:7], OP_IMM};
    if (r < 55) return {w[31:7], OP_LOAD};
    if (r < 62) return {w[31:15], 1'b0, w[13:7], OP_STORE};
    if (r < 72) return {w[31:7], OP_BRANCH};
    if (r < 76) return {w[31:7], OP_JAL};
    if (r < 80) return {w[31:15], ($urandom_range(0, 5) == 0) ? w[14:12] : 3'd0, w[11:7], OP_JALR};
    if (r < 86) return {w[31:7], OP_LUI};
    if (r < 89) return {w[31:7], OP_AUIPC};
    if (r < 95) begin
      if (sb.regs[REG_A7] == ECALL_EXIT || sb.regs[REG_A7] == ECALL_EXIT2)
        return i_word(12'($urandom_range(0, 2)), 5'd0, 3'd0, REG_A7, OP_IMM);
      return {w[31:7], OP_SYSTEM};
    end
    return i_word(12'($urandom_range(0, 4)), 5'd0, 3'd0, REG_A7, OP_IMM);
  endfunction

  task automatic send(bit mode, logic [31:0] w, logic [31:0] d);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {d, w};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(mode, w, d);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_start(logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.load_start(v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int done;
    done = 0;
    while (done < n) begin
      if (done % 100 == 0) steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) begin
        send(!sb.waiting, $urandom, $urandom);
      end else begin
        if (sb.waiting) send(1'b1, $urandom, pick_data());
        else send(1'b0, pick_instr(), $urandom);
        done++;
      end
    end
    steady = 0;
  endtask

  initial begin
    logic [31:0] starts [5];
    int sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    steady = 0;
    sink_hold = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_start(32'hFFFFFFFC);

    send(0, {20'h80000, 5'd1, OP_LUI}, 0);
    send(0, i_word(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM), 0);
    send(0, r_word(7'h01, 5'd2, 5'd1, 3'd4, 5'd3, OP_REG), 0);
    send(0, r_word(7'h01, 5'd2, 5'd1, 3'd6, 5'd4, OP_REG), 0);
    send(0, r_word(7'h01, 5'd0, 5'd1, 3'd4, 5'd5, OP_REG), 0);
    send(0, r_word(7'h01, 5'd0, 5'd2, 3'd5, 5'd6, OP_REG), 0);
    send(0, r_word(7'h01, 5'd0, 5'd1, 3'd6, 5'd7, OP_REG), 0);
    send(0, r_word(7'h01, 5'd0, 5'd2, 3'd7, 5'd8, OP_REG), 0);
    send(0, r_word(7'h20, 5'd2, 5'd1, 3'd5, 5'd9, OP_REG), 0);
    send(0, r_word(7'h00, 5'd2, 5'd2, 3'd1, 5'd9, OP_REG), 0);
    send(0, i_word(12'h7FF, 5'd2, 3'd2, 5'd0, OP_LOAD), 0);
    send(1, 0, 32'hFFFFFFFF);
    send(0, i_word(12'h800, 5'd2, 3'd0, 5'd11, OP_LOAD), 0);
    send(1, 0, 32'h00000080);
    send(1, 0, 32'h12345678);
    send(0, i_word(12'd1, 5'd0, 3'd0, REG_A7, OP_IMM), 0);
    send(0, {25'd0, OP_SYSTEM}, 0);
    send(0, {20'h00001, 5'd3, OP_LUI}, 0);
    send(1, 0, 32'hABCD0041);
    send(0, i_word(12'd2, 5'd0, 3'd0, REG_A7, OP_IMM), 0);
    send(0, {25'd0, OP_SYSTEM}, 0);
    send(0, j_word(21'h0FFFFE, 5'd1), 0);
    send(0, i_word(12'd1, 5'd2, 3'd0, 5'd5, OP_JALR), 0);
    send(0, r_word(7'h11, 5'd2, 5'd1, 3'd0, 5'd12, OP_REG), 0);
    send(0, s_word(12'hFFF, 5'd2, 5'd1, 3'd2), 0);

    starts[0] = 32'hFFFFFFFF;
    starts[1] = 32'h0;
    starts[2] = $urandom;
    starts[3] = 32'h80000000;
    starts[4] = $urandom;
    random_phase(240);
    foreach (starts[i]) begin
      write_start(starts[i]);
      random_phase(240);
    end

    sel = $urandom_range(0, 3);
    if (sel == 0 || sel == 1) begin
      if (sb.waiting) send(1, 0, $urandom);
      send(0, i_word((sel == 0) ? 12'd3 : 12'd93, 5'd0, 3'd0, REG_A7, OP_IMM), 0);
      send(0, {25'd0, OP_SYSTEM}, 0);
    end else begin
      if (sb.waiting) send(1, 0, $urandom);
      send(0, {25'($urandom_range(0, 33554431)), 7'h00}, 0);
    end
    repeat (10) send(1'($urandom_range(0, 1)), {25'($urandom_range(0, 33554431)), 7'h0C},
                     $urandom);

    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
